@@ hdl/ftws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_pkg: shared types and constants for the frame time window statistics.
// Holds the mode codes, verdict codes, sizes and controller/datapath structs.
// ----------------------------------------------------------------------------
package ftws_pkg;

  localparam int CAPACITY  = 256;
  localparam int TIME_BITS = 24;
  localparam int AW        = $clog2(CAPACITY);
  localparam int CW        = $clog2(CAPACITY + 1);
  localparam int SUM_W     = TIME_BITS + AW;

  localparam logic [1:0] MODE_PUSH   = 2'd0;
  localparam logic [1:0] MODE_REPORT = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] VERDICT_COLLECTING = 2'd0;
  localparam logic [1:0] VERDICT_BOUND      = 2'd1;
  localparam logic [1:0] VERDICT_UNBOUND    = 2'd2;
  localparam logic [1:0] VERDICT_MIXED      = 2'd3;

  localparam logic [1:0] REG_MIN_SAMPLES = 2'd0;
  localparam logic [1:0] REG_BOUND       = 2'd1;
  localparam logic [1:0] REG_UNBOUND     = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic           push;       // write the input sample into the ring
    logic           clear;      // empty the ring
    logic           sum_init;   // clear sums and peak
    logic           sum_acc;    // accumulate entry at scan address
    logic           div_start;  // start the divider sequence
    logic           sel_init;   // start a percentile selection pass
    logic           sel_acc;    // count entries at scan address
    logic           sel_bit;    // settle one bit of the percentile
    logic           sel_col;    // 0 frame, 1 game
    logic           sel_store;  // latch selected value
    logic           finish;     // compute verdict and show the result
    logic [AW-1:0]  addr;       // scan address
  } ftws_cmd_t;

  typedef struct packed {
    logic           div_done;
    logic [CW-1:0]  fill;
  } ftws_sts_t;

endpackage

@@ hdl/ftws_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_ctrl: sequencer for push, clear and report items.
// Walks the ring once for sums, then once per bit for each percentile.
// ----------------------------------------------------------------------------
module ftws_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [1:0]          mode,
  input  ftws_pkg::ftws_sts_t sts,
  output ftws_pkg::ftws_cmd_t cmd,
  output logic                busy
);
  import ftws_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_SUM  = 8'b00000010,
    S_SUMW = 8'b00000100,
    S_DIV  = 8'b00001000,
    S_SEL  = 8'b00010000,
    S_SELW = 8'b00100000,
    S_BIT  = 8'b01000000,
    S_DONE = 8'b10000000
  } state_t;

  state_t          state, state_next;
  logic [CW-1:0]   idx, idx_next;
  logic [4:0]      bitn, bitn_next;
  logic            col, col_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
      bitn  <= '0;
      col   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      bitn  <= bitn_next;
      col   <= col_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    bitn_next  = bitn;
    col_next   = col;
    cmd        = '0;
    cmd.addr   = idx[AW-1:0];
    cmd.sel_col = col;
    busy       = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode)
            MODE_PUSH:  cmd.push  = 1'b1;
            MODE_CLEAR: cmd.clear = 1'b1;
            MODE_REPORT: begin
              cmd.sum_init = 1'b1;
              idx_next     = '0;
              if (sts.fill == '0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_SUM;
              end
            end
            default: ;
          endcase
        end
      end
      // Memory read is registered: entry idx is presented in the next cycle.
      S_SUM: begin
        idx_next   = idx + 1'b1;
        state_next = S_SUMW;
      end
      S_SUMW: begin
        cmd.sum_acc = 1'b1;
        if (idx == sts.fill) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          col_next   = 1'b0;
          bitn_next  = 5'(TIME_BITS - 1);
          idx_next   = '0;
          cmd.sel_init = 1'b1;
          state_next = S_SEL;
        end
      end
      S_SEL: begin
        idx_next   = idx + 1'b1;
        state_next = S_SELW;
      end
      S_SELW: begin
        cmd.sel_acc = 1'b1;
        if (idx == sts.fill) begin
          state_next = S_BIT;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      S_BIT: begin
        cmd.sel_bit = 1'b1;
        idx_next    = '0;
        if (bitn == '0) begin
          cmd.sel_store = 1'b1;
          if (col) begin
            state_next = S_DONE;
          end else begin
            col_next     = 1'b1;
            bitn_next    = 5'(TIME_BITS - 1);
            state_next   = S_SEL;
          end
        end else begin
          bitn_next  = bitn - 1'b1;
          state_next = S_SEL;
        end
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    if (state == S_BIT && bitn == '0 && !col) cmd.sel_init = 1'b1;
    if (state == S_SEL || state == S_SELW || state == S_BIT) cmd.sel_col = col;
  end

endmodule

@@ hdl/ftws_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_div: restoring divider, one quotient bit per cycle.
// Used in turn for the four means, fps and game share.
// ----------------------------------------------------------------------------
module ftws_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [41:0] dividend,
  input  logic [33:0] divisor,
  output logic [41:0] quotient,
  output logic        done
);
  import ftws_pkg::*;

  logic [5:0]  cnt;
  logic        run;
  logic [41:0] q;
  logic [34:0] rem;
  logic [34:0] trial;

  assign trial    = {rem[33:0], q[41]} - {1'b0, divisor};
  assign quotient = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 6'd42;
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == 6'd1) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      q   <= dividend;
      rem <= '0;
    end else if (run) begin
      if (!trial[34]) begin
        rem <= trial;
        q   <= {q[40:0], 1'b1};
      end else begin
        rem <= {rem[33:0], q[41]};
        q   <= {q[40:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/ftws_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ftws_dp: sample ring, sums, divider sequence, percentile bit search and
// result registers.
// ----------------------------------------------------------------------------
module ftws_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  ftws_pkg::ftws_cmd_t           cmd,
  output ftws_pkg::ftws_sts_t           sts,
  input  logic [ftws_pkg::TIME_BITS-1:0] in_frame,
  input  logic [ftws_pkg::TIME_BITS-1:0] in_game,
  input  logic [ftws_pkg::TIME_BITS-1:0] in_slate,
  input  logic [ftws_pkg::TIME_BITS-1:0] in_lod,
  input  logic [8:0]                    min_samples,
  input  logic [9:0]                    bound_permille,
  input  logic [9:0]                    unbound_permille,
  output logic                          done,
  output logic [8:0]                    fill_count,
  output logic [23:0]                   frame_mean,
  output logic [23:0]                   game_mean,
  output logic [23:0]                   slate_mean,
  output logic [23:0]                   lod_mean,
  output logic [23:0]                   lod_peak,
  output logic [19:0]                   frames_per_second,
  output logic signed [24:0]            outside_mean,
  output logic [15:0]                   game_share,
  output logic [23:0]                   frame_pctl,
  output logic [23:0]                   game_pctl,
  output logic [1:0]                    verdict_code
);
  import ftws_pkg::*;

  localparam int TB = TIME_BITS;

  logic [4*TB-1:0] ring [CAPACITY];
  logic [4*TB-1:0] rd;
  logic [AW-1:0]   head;
  logic [CW-1:0]   fill;
  logic [AW-1:0]   wslot;

  assign wslot = (fill == CW'(CAPACITY)) ? head : fill[AW-1:0];
  assign sts.fill = fill;

  always_ff @(posedge clk) begin
    if (cmd.push) ring[wslot] <= {in_lod, in_slate, in_game, in_frame};
    rd <= ring[cmd.addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      fill <= '0;
      head <= '0;
    end else if (cmd.push) begin
      if (fill == CW'(CAPACITY)) head <= head + 1'b1;
      else fill <= fill + 1'b1;
    end
  end

  // Sums and lod peak.
  logic [SUM_W-1:0] sum_f, sum_g, sum_s, sum_l;
  logic [TB-1:0]    peak;
  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      sum_f <= '0; sum_g <= '0; sum_s <= '0; sum_l <= '0; peak <= '0;
    end else if (cmd.sum_acc) begin
      sum_f <= sum_f + SUM_W'(rd[TB-1:0]);
      sum_g <= sum_g + SUM_W'(rd[2*TB-1:TB]);
      sum_s <= sum_s + SUM_W'(rd[3*TB-1:2*TB]);
      sum_l <= sum_l + SUM_W'(rd[4*TB-1:3*TB]);
      if (rd[4*TB-1:3*TB] > peak) peak <= rd[4*TB-1:3*TB];
    end
  end

  // Divider sequence: four means, then fps, then share.
  logic [2:0]  dstep;
  logic        drun;
  logic        dgo;
  logic [41:0] dvd;
  logic [33:0] dvs;
  logic [41:0] quo;
  logic        ddone;
  logic [TB-1:0] fm, gm, sm, lm;
  logic [41:0] shr;
  logic [41:0] fpsq;

  always_comb begin
    dvd = '0;
    dvs = 34'(fill);
    case (dstep)
      3'd0: dvd = 42'(sum_f);
      3'd1: dvd = 42'(sum_g);
      3'd2: dvd = 42'(sum_s);
      3'd3: dvd = 42'(sum_l);
      3'd4: begin dvd = 42'd1000000; dvs = 34'(fm); end
      3'd5: begin dvd = 42'(gm) * 42'd1000; dvs = 34'(fm); end
      default: ;
    endcase
  end

  ftws_div u_div (
    .clk(clk), .rst(rst), .go(dgo), .dividend(dvd), .divisor(dvs),
    .quotient(quo), .done(ddone)
  );

  logic dlast;
  always_ff @(posedge clk) begin
    if (rst) begin
      drun  <= 1'b0;
      dgo   <= 1'b0;
      dstep <= '0;
      dlast <= 1'b0;
    end else begin
      dgo   <= 1'b0;
      dlast <= 1'b0;
      if (cmd.div_start) begin
        drun  <= 1'b1;
        dstep <= '0;
        dgo   <= 1'b1;
      end else if (drun && ddone) begin
        case (dstep)
          3'd0: fm <= quo[TB-1:0];
          3'd1: gm <= quo[TB-1:0];
          3'd2: sm <= quo[TB-1:0];
          3'd3: lm <= quo[TB-1:0];
          3'd4: fpsq <= quo;
          default: shr <= quo;
        endcase
        // Skip fps and share when the frame mean is zero.
        if (dstep == 3'd5 || (dstep == 3'd3 && fm == '0)) begin
          drun  <= 1'b0;
          dlast <= 1'b1;
          if (fm == '0) begin
            fpsq <= '0;
            shr  <= '0;
          end
        end else begin
          dstep <= dstep + 1'b1;
          dgo   <= 1'b1;
        end
      end
    end
  end
  assign sts.div_done = dlast;

  // Percentile: bitwise search for the k-th smallest.
  logic [CW-1:0]  kk;
  logic [TB-1:0]  prefix;
  logic [TB-1:0]  cand;
  logic [CW-1:0]  cnt_lt;
  logic [4:0]     bpos;
  logic [TB-1:0]  val;
  logic [TB-1:0]  fp99;
  logic [15:0]    kprod;
  logic [28:0]    kmul;

  // k = floor(99*(n-1)/100). The division by 100 is a multiply by 5243 and a
  // shift by 19, which is exact for every product up to 99*255.
  assign kprod = 16'd99 * 16'(fill - 1'b1);
  assign kmul  = 29'(kprod) * 29'd5243;
  assign val   = cmd.sel_col ? rd[2*TB-1:TB] : rd[TB-1:0];
  assign cand  = prefix | (TB'(1) << bpos);

  always_ff @(posedge clk) begin
    if (cmd.sel_init) begin
      kk     <= kmul[19 +: CW];
      prefix <= '0;
      bpos   <= 5'(TB - 1);
      cnt_lt <= '0;
    end else if (cmd.sel_acc) begin
      if (val < cand) cnt_lt <= cnt_lt + 1'b1;
    end else if (cmd.sel_bit) begin
      // Fewer than k+1 values below cand: the answer has this bit set.
      if (cnt_lt <= kk) prefix <= cand;
      bpos   <= bpos - 1'b1;
      cnt_lt <= '0;
    end
    // The frame pass ends in the same cycle that starts the game pass.
    if (cmd.sel_store && !cmd.sel_col) fp99 <= (cnt_lt <= kk) ? cand : prefix;
  end

  // Output stage.
  logic [34:0] gk, bk, uk;
  logic        any;
  assign any = (fill != '0);
  assign gk  = 35'(gm) * 35'd1000;
  assign bk  = 35'(bound_permille) * 35'(fm);
  assign uk  = 35'(unbound_permille) * 35'(fm);

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      fill_count        <= 9'(fill);
      frame_mean        <= any ? fm : '0;
      game_mean         <= any ? gm : '0;
      slate_mean        <= any ? sm : '0;
      lod_mean          <= any ? lm : '0;
      lod_peak          <= any ? peak : '0;
      frames_per_second <= any ? fpsq[19:0] : '0;
      outside_mean      <= any ? ($signed({1'b0, fm}) - $signed({1'b0, gm})) : '0;
      game_share        <= !any ? '0 : (shr > 42'd65535) ? 16'hFFFF : shr[15:0];
      frame_pctl        <= any ? fp99 : '0;
      game_pctl         <= any ? prefix : '0;
      if (!any || fill < CW'(min_samples) || fm == '0) verdict_code <= VERDICT_COLLECTING;
      else if (gk >= bk) verdict_code <= VERDICT_BOUND;
      else if (gk <= uk) verdict_code <= VERDICT_UNBOUND;
      else verdict_code <= VERDICT_MIXED;
    end
  end

endmodule

@@ hdl/frame_time_window_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_time_window_stats: sliding window of frame timing samples.
// Push and clear leave busy low, so they may follow back to back.
// A report shows on done after one ring pass for the sums, six divisions (two
// fewer when the frame mean is zero), and a ring pass per bit of each 24-bit
// percentile; an empty window goes straight to the result.
// Busy falls as done rises; no receiver stall.
// Reset clears the window and loads the register defaults.
// ----------------------------------------------------------------------------
module frame_time_window_stats (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic [1:0]  mode,
  input  logic [23:0] frame_us,
  input  logic [23:0] game_us,
  input  logic [23:0] slate_us,
  input  logic [23:0] lod_us,
  output logic        done,
  output logic [8:0]  fill_count,
  output logic [23:0] frame_mean,
  output logic [23:0] game_mean,
  output logic [23:0] slate_mean,
  output logic [23:0] lod_mean,
  output logic [23:0] lod_peak,
  output logic [19:0] frames_per_second,
  output logic signed [24:0] outside_mean,
  output logic [15:0] game_share,
  output logic [23:0] frame_pctl,
  output logic [23:0] game_pctl,
  output logic [1:0]  verdict_code
);
  import ftws_pkg::*;

  logic [8:0] min_samples;
  logic [9:0] bound_permille;
  logic [9:0] unbound_permille;
  ftws_cmd_t  cmd;
  ftws_sts_t  sts;

  // Configuration registers; writes must be made only while idle, which the block itself does not enforce.
  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples      <= 9'd60;
      bound_permille   <= 10'd850;
      unbound_permille <= 10'd550;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MIN_SAMPLES: min_samples      <= cfg_data[8:0];
        REG_BOUND:       bound_permille   <= cfg_data;
        REG_UNBOUND:     unbound_permille <= cfg_data;
        default: ;
      endcase
    end
  end

  ftws_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .mode(mode), .sts(sts), .cmd(cmd), .busy(busy)
  );

  ftws_dp u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_frame(frame_us), .in_game(game_us), .in_slate(slate_us), .in_lod(lod_us),
    .min_samples(min_samples), .bound_permille(bound_permille),
    .unbound_permille(unbound_permille), .done(done),
    .fill_count(fill_count), .frame_mean(frame_mean), .game_mean(game_mean),
    .slate_mean(slate_mean), .lod_mean(lod_mean), .lod_peak(lod_peak),
    .frames_per_second(frames_per_second), .outside_mean(outside_mean),
    .game_share(game_share), .frame_pctl(frame_pctl), .game_pctl(game_pctl),
    .verdict_code(verdict_code)
  );

endmodule
